FILE: rtl/gcd_lcm_unit_top_assert.svh
// ---------------------------------------------------------------------------
// gcd_lcm_unit_top_assert.svh
// Assertion macros for the GCD/LCM unit. They compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef GCD_LCM_UNIT_TOP_ASSERT_SVH
`define GCD_LCM_UNIT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GCLU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcd_lcm_unit assertion failed");
// next-cycle implication
`define GCLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcd_lcm_unit assertion failed");
`else
`define GCLU_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define GCLU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/gclu_pkg.sv
// ---------------------------------------------------------------------------
// gclu_pkg
// Item types, control structs and codes shared by the GCD/LCM unit.
// ---------------------------------------------------------------------------
package gclu_pkg;

   // command codes
   localparam logic CMD_GCD = 1'b0;
   localparam logic CMD_LCM = 1'b1;

   // shared adder operation codes
   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   // input item
   typedef struct packed {
      logic        command;
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } gclu_req_type;

   // result item
   typedef struct packed {
      logic [63:0] result;
      logic        error;
   } gclu_rsp_type;

   // top -> core control
   typedef struct packed {
      logic start;
      logic take;
   } gclu_ctl_type;

   // core -> top status
   typedef struct packed {
      logic idle;
      logic done;
   } gclu_sts_type;

endpackage

FILE: rtl/gclu_alu.sv
// ---------------------------------------------------------------------------
// gclu_alu
// Shared add/subtract unit with carry out; carry out set on subtract means
// no borrow.
// ---------------------------------------------------------------------------
module gclu_alu #(
   parameter int AW = 64
) (
   input  logic [AW-1:0] p,
   input  logic [AW-1:0] q,
   input  logic          op,
   output logic [AW-1:0] res,
   output logic          cout
);
   import gclu_pkg::*;

   logic [AW-1:0] q_eff;
   logic [AW:0]   sum;

   // subtract as p + ~q + 1
   assign q_eff = (op == ALU_SUB) ? ~q : q;
   assign sum   = {1'b0, p} + {1'b0, q_eff} + {{AW{1'b0}}, (op == ALU_SUB)};
   assign res   = sum[AW-1:0];
   assign cout  = sum[AW];

endmodule

FILE: rtl/gclu_core.sv
// ---------------------------------------------------------------------------
// gclu_core
// Sequencer and working registers: binary GCD, restoring division of a by
// the GCD and shift-add multiply by b, all through one shared adder.
// ---------------------------------------------------------------------------
module gclu_core #(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gclu_pkg::gclu_ctl_type ctl,
   input  gclu_pkg::gclu_req_type req,
   output gclu_pkg::gclu_sts_type sts,
   output gclu_pkg::gclu_rsp_type rsp
);
   import gclu_pkg::*;

   localparam int AW = 2 * W;
   localparam int CW = $clog2(W + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_TWOS    = 3'd1;
   localparam logic [2:0] S_ODDX    = 3'd2;
   localparam logic [2:0] S_GCD     = 3'd3;
   localparam logic [2:0] S_UNSHIFT = 3'd4;
   localparam logic [2:0] S_DIV     = 3'd5;
   localparam logic [2:0] S_MUL     = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [AW-1:0] acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          cmd_ff, cmd_in;
   logic          err_ff, err_in;

   logic [AW-1:0] alu_p, alu_q, alu_res;
   logic          alu_op, alu_cout;
   logic [W:0]    rem_sh;
   logic [W-1:0]  mul_addend;
   logic [W-1:0]  op_a, op_b;

   assign op_a       = req.operand_a[W-1:0];
   assign op_b       = req.operand_b[W-1:0];
   assign rem_sh     = {rem_ff, a_ff[W-1]};
   assign mul_addend = a_ff[W-1] ? b_ff : '0;

   gclu_alu #(.AW(AW)) u_alu (
      .p    (alu_p),
      .q    (alu_q),
      .op   (alu_op),
      .res  (alu_res),
      .cout (alu_cout)
   );

   // shared adder operand select
   always_comb begin
      unique case (state_ff)
         S_GCD: begin
            alu_p  = {{W{1'b0}}, y_ff};
            alu_q  = {{W{1'b0}}, x_ff};
            alu_op = ALU_SUB;
         end
         S_DIV: begin
            alu_p  = {{(W-1){1'b0}}, rem_sh};
            alu_q  = {{W{1'b0}}, x_ff};
            alu_op = ALU_SUB;
         end
         S_MUL: begin
            alu_p  = {acc_ff[AW-2:0], 1'b0};
            alu_q  = {{W{1'b0}}, mul_addend};
            alu_op = ALU_ADD;
         end
         default: begin
            alu_p  = '0;
            alu_q  = '0;
            alu_op = ALU_ADD;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      rem_in   = rem_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      cmd_in   = cmd_ff;
      err_in   = err_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               a_in   = op_a;
               b_in   = op_b;
               x_in   = op_a;
               y_in   = op_b;
               cmd_in = req.command;
               cnt_in = '0;
               if ((op_a == '0) || (op_b == '0)) begin
                  err_in   = 1'b1;
                  acc_in   = '0;
                  state_in = S_DONE;
               end else begin
                  err_in   = 1'b0;
                  state_in = S_TWOS;
               end
            end
         end
         // strip common factors of two
         S_TWOS: begin
            if (((x_ff | y_ff) & W'(1)) == '0) begin
               x_in   = {1'b0, x_ff[W-1:1]};
               y_in   = {1'b0, y_ff[W-1:1]};
               cnt_in = cnt_ff + CW'(1);
            end else begin
               state_in = S_ODDX;
            end
         end
         // make x odd
         S_ODDX: begin
            if (!x_ff[0]) begin
               x_in = {1'b0, x_ff[W-1:1]};
            end else begin
               state_in = S_GCD;
            end
         end
         // subtract loop; odd minus odd is even, so halve in the same step
         S_GCD: begin
            if (y_ff == '0) begin
               state_in = S_UNSHIFT;
            end else if (!y_ff[0]) begin
               y_in = {1'b0, y_ff[W-1:1]};
            end else if (!alu_cout) begin
               x_in = y_ff;
               y_in = x_ff;
            end else begin
               y_in = {1'b0, alu_res[W-1:1]};
            end
         end
         // restore the common power of two
         S_UNSHIFT: begin
            if (cnt_ff != '0) begin
               x_in   = {x_ff[W-2:0], 1'b0};
               cnt_in = cnt_ff - CW'(1);
            end else if (cmd_ff == CMD_LCM) begin
               rem_in   = '0;
               state_in = S_DIV;
            end else begin
               acc_in   = {{W{1'b0}}, x_ff};
               state_in = S_DONE;
            end
         end
         // a / gcd, one quotient bit per step, quotient shifts into a
         S_DIV: begin
            rem_in = alu_cout ? alu_res[W-1:0] : rem_sh[W-1:0];
            a_in   = {a_ff[W-2:0], alu_cout};
            if (cnt_ff == CW'(W - 1)) begin
               cnt_in   = '0;
               acc_in   = '0;
               state_in = S_MUL;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         // quotient * b, MSB first
         S_MUL: begin
            acc_in = alu_res;
            a_in   = {a_ff[W-2:0], 1'b0};
            if (cnt_ff == CW'(W - 1)) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_DONE: begin
            if (ctl.take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      cmd_ff <= cmd_in;
      err_ff <= err_in;
   end

   assign sts.idle   = (state_ff == S_IDLE);
   assign sts.done   = (state_ff == S_DONE);
   assign rsp.result = 64'(acc_ff);
   assign rsp.error  = err_ff;

endmodule

FILE: rtl/gcd_lcm_unit_top.sv
// From acceptance to rsp_valid: a zero operand goes straight to the done state; otherwise
// the binary GCD steps (shifts, subtracts and unshifts) run for GCD, and for LCM a
// division by the GCD and then a multiply by b follow.
// The single shared adder and its sequencer handle one item at a time: a new item is taken
// only once the last one has left the core, which waits while the output is stalled.
// Reset: synchronous, clears the sequencer and the output valid; no clearing pass.
// ---------------------------------------------------------------------------
// gcd_lcm_unit_top
// GCD or LCM of two unsigned operands, with error on a zero operand.
// ---------------------------------------------------------------------------
`include "gcd_lcm_unit_top_assert.svh"

module gcd_lcm_unit_top #(
   parameter int OPERAND_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gclu_pkg::gclu_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output gclu_pkg::gclu_rsp_type rsp_data
);
   import gclu_pkg::*;

   gclu_ctl_type ctl;
   gclu_sts_type sts;
   gclu_rsp_type core_rsp;

   logic         rsp_valid_ff, rsp_valid_in;
   gclu_rsp_type rsp_data_ff, rsp_data_in;
   logic         out_free;
   logic         rsp_err_shown;
   logic         rsp_ok_shown;

   // take a new item only while the core is idle
   assign req_stall = !sts.idle;
   assign ctl.start = req_valid && !req_stall;

   // output register: load when empty or being drained
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign ctl.take = sts.done && out_free;

   gclu_core #(.W(OPERAND_WIDTH)) u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .req   (req_data),
      .sts   (sts),
      .rsp   (core_rsp)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctl.take) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_rsp;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // result item on the output, split by error flag
   assign rsp_err_shown = rsp_valid && rsp_data.error;
   assign rsp_ok_shown  = rsp_valid && !rsp_data.error;

   // checks
   `GCLU_ASSERT_NEXT(a_busy_after_accept, clock, reset, ctl.start, req_stall)
   `GCLU_ASSERT_NEXT(a_take_loads_output, clock, reset, ctl.take, rsp_valid)
   `GCLU_ASSERT_IMPLY(a_error_zero_result, clock, reset, rsp_err_shown, rsp_data.result == 64'd0)
   `GCLU_ASSERT_IMPLY(a_good_result_nonzero, clock, reset, rsp_ok_shown, |rsp_data.result)

endmodule
